// File: sv/small_matrix_inverse_defines.svh
// Assertion macros for the small matrix inverse block.
`ifndef SMALL_MATRIX_INVERSE_DEFINES_SVH
`define SMALL_MATRIX_INVERSE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SMI_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SMI_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/smi_pkg.sv
// Widths, types and codes shared by the small matrix inverse files.
package smi_pkg;

    localparam int DW    = 32;           // entry width
    localparam int FB    = 16;           // fraction bits
    localparam int SH    = 2 * FB;       // numerator scale
    localparam int PW    = 2 * DW;       // entry product
    localparam int CW    = PW + 1;       // cofactor
    localparam int PLW   = 2 * DW + 1;   // entry times cofactor half
    localparam int PRW   = 3 * DW + 1;   // entry times cofactor
    localparam int DETW  = PRW + 2;      // determinant
    localparam int NW    = CW + SH;      // scaled numerator
    localparam int NENT  = 9;
    localparam int NPROD = 18;
    localparam int NST   = 8 + DW;       // pipeline stages

    typedef enum logic [1:0] {
        ORD_NONE = 2'd0,
        ORD_1    = 2'd1,
        ORD_2    = 2'd2,
        ORD_3    = 2'd3
    } order_t;

    typedef logic signed [DW-1:0]   ent_t;
    typedef logic signed [PW-1:0]   prod_t;
    typedef logic signed [CW-1:0]   cof_t;
    typedef logic signed [PLW-1:0]  plw_t;
    typedef logic signed [PRW-1:0]  prw_t;
    typedef logic signed [DETW-1:0] det_t;

endpackage

// File: sv/smi_if.sv
// Handshake channels for matrices in and inverses out.
interface smi_in_if;
    logic             valid;
    logic             ready;
    smi_pkg::order_t  order;
    smi_pkg::ent_t    m00;
    smi_pkg::ent_t    m01;
    smi_pkg::ent_t    m02;
    smi_pkg::ent_t    m10;
    smi_pkg::ent_t    m11;
    smi_pkg::ent_t    m12;
    smi_pkg::ent_t    m20;
    smi_pkg::ent_t    m21;
    smi_pkg::ent_t    m22;

    modport source (output valid, order, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, order, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface smi_out_if;
    logic           valid;
    logic           ready;
    smi_pkg::ent_t  q00;
    smi_pkg::ent_t  q01;
    smi_pkg::ent_t  q02;
    smi_pkg::ent_t  q10;
    smi_pkg::ent_t  q11;
    smi_pkg::ent_t  q12;
    smi_pkg::ent_t  q20;
    smi_pkg::ent_t  q21;
    smi_pkg::ent_t  q22;
    logic           singular;
    logic           saturated;

    modport source (output valid, q00, q01, q02, q10, q11, q12, q20, q21, q22,
                    singular, saturated, input ready);
    modport sink (input valid, q00, q01, q02, q10, q11, q12, q20, q21, q22,
                  singular, saturated, output ready);
endinterface

// File: sv/small_matrix_inverse.sv
// Small matrix inverse top level: adjugate over determinant, pipelined.
//
//  channel  dir  beat
//  mat      in   order, m00..m22 (signed Q16.16)
//  inv      out  q00..q22, singular, saturated
//
// One beat per cycle in, one per cycle out while the inv channel is not stalled; the depth is
// set by the restoring divider that resolves one quotient bit per stage in all nine lanes.
// Each stage holds its beat until the next one frees, so bubbles close up under stall.
// Reset (rst_n, asynchronous) clears only the stage valid bits.
`include "small_matrix_inverse_defines.svh"

module small_matrix_inverse
(
    input logic        clk,
    input logic        rst_n,
    smi_in_if.sink     mat,
    smi_out_if.source  inv
);

    logic [smi_pkg::NST-1:0] vld_reg;
    logic [smi_pkg::NST-1:0] en;

    always_comb
    begin
        en[smi_pkg::NST-1] = !vld_reg[smi_pkg::NST-1] || inv.ready;
        for (int s = smi_pkg::NST - 2; s >= 0; s--)
        begin
            en[s] = !vld_reg[s] || en[s+1];
        end
    end

    assign mat.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= mat.valid;
            end
            for (int s = 1; s < smi_pkg::NST; s++)
            begin
                if (en[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // ---- stage 0: the eighteen entry products
    smi_pkg::prod_t  prod_next [smi_pkg::NPROD];
    smi_pkg::prod_t  prod_reg  [smi_pkg::NPROD];
    smi_pkg::order_t ord0_reg;
    smi_pkg::ent_t   a0_reg, b0_reg, c0_reg, d0_reg, e0_reg;

    function automatic smi_pkg::prod_t mul(input smi_pkg::ent_t x, input smi_pkg::ent_t y);
        return smi_pkg::prod_t'(x) * smi_pkg::prod_t'(y);
    endfunction

    always_comb
    begin
        prod_next[0]  = mul(mat.m11, mat.m22);
        prod_next[1]  = mul(mat.m12, mat.m21);
        prod_next[2]  = mul(mat.m02, mat.m21);
        prod_next[3]  = mul(mat.m01, mat.m22);
        prod_next[4]  = mul(mat.m01, mat.m12);
        prod_next[5]  = mul(mat.m02, mat.m11);
        prod_next[6]  = mul(mat.m12, mat.m20);
        prod_next[7]  = mul(mat.m10, mat.m22);
        prod_next[8]  = mul(mat.m00, mat.m22);
        prod_next[9]  = mul(mat.m02, mat.m20);
        prod_next[10] = mul(mat.m02, mat.m10);
        prod_next[11] = mul(mat.m00, mat.m12);
        prod_next[12] = mul(mat.m10, mat.m21);
        prod_next[13] = mul(mat.m11, mat.m20);
        prod_next[14] = mul(mat.m01, mat.m20);
        prod_next[15] = mul(mat.m00, mat.m21);
        prod_next[16] = mul(mat.m00, mat.m11);
        prod_next[17] = mul(mat.m01, mat.m10);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod_next;
            ord0_reg <= mat.order;
            a0_reg   <= mat.m00;
            b0_reg   <= mat.m01;
            c0_reg   <= mat.m02;
            d0_reg   <= mat.m10;
            e0_reg   <= mat.m11;
        end
    end

    // ---- stage 1: adjugate entries, chosen by order
    smi_pkg::cof_t   cof_next [smi_pkg::NENT];
    smi_pkg::cof_t   cof1_reg [smi_pkg::NENT];
    smi_pkg::cof_t   det2_1_reg;
    smi_pkg::ent_t   a1_reg, b1_reg, c1_reg;
    smi_pkg::order_t ord1_reg;

    always_comb
    begin
        for (int k = 0; k < smi_pkg::NENT; k++)
        begin
            cof_next[k] = '0;
        end
        case (ord0_reg)
            smi_pkg::ORD_3:
            begin
                for (int k = 0; k < smi_pkg::NENT; k++)
                begin
                    cof_next[k] = smi_pkg::cof_t'(prod_reg[2*k])
                                - smi_pkg::cof_t'(prod_reg[2*k+1]);
                end
            end
            smi_pkg::ORD_2:
            begin
                cof_next[0] = smi_pkg::cof_t'(e0_reg);
                cof_next[1] = -smi_pkg::cof_t'(b0_reg);
                cof_next[3] = -smi_pkg::cof_t'(d0_reg);
                cof_next[4] = smi_pkg::cof_t'(a0_reg);
            end
            smi_pkg::ORD_1:
            begin
                cof_next[0] = smi_pkg::cof_t'(1);
            end
            default:
            begin
                cof_next[0] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cof1_reg   <= cof_next;
            det2_1_reg <= smi_pkg::cof_t'(prod_reg[16]) - smi_pkg::cof_t'(prod_reg[17]);
            a1_reg     <= a0_reg;
            b1_reg     <= b0_reg;
            c1_reg     <= c0_reg;
            ord1_reg   <= ord0_reg;
        end
    end

    // ---- stage 2: first-row entries times cofactor halves
    smi_pkg::plw_t   pl_next [3];
    smi_pkg::plw_t   ph_next [3];
    smi_pkg::plw_t   pl2_reg [3];
    smi_pkg::plw_t   ph2_reg [3];
    smi_pkg::cof_t   cof2_reg [smi_pkg::NENT];
    smi_pkg::cof_t   det2_2_reg;
    smi_pkg::ent_t   a2_reg;
    smi_pkg::order_t ord2_reg;
    smi_pkg::ent_t   xs [3];
    smi_pkg::cof_t   cs [3];

    always_comb
    begin
        xs[0] = a1_reg;
        xs[1] = b1_reg;
        xs[2] = c1_reg;
        cs[0] = cof1_reg[0];
        cs[1] = cof1_reg[3];
        cs[2] = cof1_reg[6];
        for (int k = 0; k < 3; k++)
        begin
            pl_next[k] = xs[k] * $signed({1'b0, cs[k][smi_pkg::DW-1:0]});
            ph_next[k] = xs[k] * $signed(cs[k][smi_pkg::CW-1:smi_pkg::DW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            pl2_reg    <= pl_next;
            ph2_reg    <= ph_next;
            cof2_reg   <= cof1_reg;
            det2_2_reg <= det2_1_reg;
            a2_reg     <= a1_reg;
            ord2_reg   <= ord1_reg;
        end
    end

    // ---- stage 3: join the halves
    smi_pkg::prw_t   tp_next [3];
    smi_pkg::prw_t   tp3_reg [3];
    smi_pkg::cof_t   cof3_reg [smi_pkg::NENT];
    smi_pkg::cof_t   det2_3_reg;
    smi_pkg::ent_t   a3_reg;
    smi_pkg::order_t ord3_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            tp_next[k] = $signed({ph2_reg[k], {smi_pkg::DW{1'b0}}})
                       + smi_pkg::prw_t'(pl2_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            tp3_reg    <= tp_next;
            cof3_reg   <= cof2_reg;
            det2_3_reg <= det2_2_reg;
            a3_reg     <= a2_reg;
            ord3_reg   <= ord2_reg;
        end
    end

    // ---- stage 4: determinant
    smi_pkg::det_t   det_next;
    smi_pkg::det_t   det4_reg;
    smi_pkg::cof_t   cof4_reg [smi_pkg::NENT];
    smi_pkg::order_t ord4_reg;

    always_comb
    begin
        case (ord3_reg)
            smi_pkg::ORD_3: det_next = smi_pkg::det_t'(tp3_reg[0]) + smi_pkg::det_t'(tp3_reg[1])
                                     + smi_pkg::det_t'(tp3_reg[2]);
            smi_pkg::ORD_2: det_next = smi_pkg::det_t'(det2_3_reg);
            smi_pkg::ORD_1: det_next = smi_pkg::det_t'(a3_reg);
            default:        det_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            det4_reg <= det_next;
            cof4_reg <= cof3_reg;
            ord4_reg <= ord3_reg;
        end
    end

    // ---- stage 5: magnitudes and signs
    logic [smi_pkg::DETW-1:0] dabs_next;
    smi_pkg::det_t            dneg_val;
    logic [smi_pkg::NW-1:0]   num_next [smi_pkg::NENT];
    logic                     neg_next [smi_pkg::NENT];
    smi_pkg::cof_t            cabs;
    logic [smi_pkg::DETW-1:0] dabs5_reg;
    logic                     dz5_reg;
    logic                     sg5_reg;
    logic [smi_pkg::NW-1:0]   num5_reg [smi_pkg::NENT];
    logic                     neg5_reg [smi_pkg::NENT];

    always_comb
    begin
        dneg_val  = -det4_reg;
        dabs_next = det4_reg[smi_pkg::DETW-1] ? dneg_val : det4_reg;
        for (int k = 0; k < smi_pkg::NENT; k++)
        begin
            cabs        = cof4_reg[k][smi_pkg::CW-1] ? -cof4_reg[k] : cof4_reg[k];
            num_next[k] = {cabs, {smi_pkg::SH{1'b0}}};
            neg_next[k] = cof4_reg[k][smi_pkg::CW-1] ^ det4_reg[smi_pkg::DETW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            dabs5_reg <= dabs_next;
            dz5_reg   <= (det4_reg == '0);
            sg5_reg   <= (det4_reg == '0) && (ord4_reg != smi_pkg::ORD_NONE);
            num5_reg  <= num_next;
            neg5_reg  <= neg_next;
        end
    end

    // ---- stage 6 onwards: restoring division, overflow check at stage 6, then one quotient bit per stage
    logic [smi_pkg::DETW-1:0] rem_reg  [smi_pkg::DW+1][smi_pkg::NENT];
    logic [smi_pkg::DW-1:0]   low_reg  [smi_pkg::DW+1][smi_pkg::NENT];
    logic [smi_pkg::DW-1:0]   q_reg    [smi_pkg::DW+1][smi_pkg::NENT];
    logic                     ovf_reg  [smi_pkg::DW+1][smi_pkg::NENT];
    logic                     neg_reg  [smi_pkg::DW+1][smi_pkg::NENT];
    logic [smi_pkg::DETW-1:0] dabs_reg [smi_pkg::DW+1];
    logic                     dz_reg   [smi_pkg::DW+1];
    logic                     sg_reg   [smi_pkg::DW+1];
    logic [smi_pkg::DETW-1:0] top      [smi_pkg::NENT];

    // quotient would need more than DW bits when the upper numerator reaches the divisor
    always_comb
    begin
        for (int k = 0; k < smi_pkg::NENT; k++)
        begin
            top[k] = smi_pkg::DETW'(num5_reg[k][smi_pkg::NW-1:smi_pkg::DW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            for (int k = 0; k < smi_pkg::NENT; k++)
            begin
                ovf_reg[0][k] <= (top[k] >= dabs5_reg);
                rem_reg[0][k] <= (top[k] >= dabs5_reg) ? '0 : top[k];
                low_reg[0][k] <= num5_reg[k][smi_pkg::DW-1:0];
                q_reg[0][k]   <= '0;
                neg_reg[0][k] <= neg5_reg[k];
            end
            dabs_reg[0] <= dabs5_reg;
            dz_reg[0]   <= dz5_reg;
            sg_reg[0]   <= sg5_reg;
        end
    end

    for (genvar j = 1; j <= smi_pkg::DW; j++)
    begin : g_div
        logic [smi_pkg::DETW:0]   t  [smi_pkg::NENT];
        logic                     ge [smi_pkg::NENT];
        logic [smi_pkg::DETW:0]   df [smi_pkg::NENT];

        always_comb
        begin
            for (int k = 0; k < smi_pkg::NENT; k++)
            begin
                t[k]  = {rem_reg[j-1][k], low_reg[j-1][k][smi_pkg::DW-1]};
                ge[k] = (t[k] >= {1'b0, dabs_reg[j-1]});
                df[k] = t[k] - {1'b0, dabs_reg[j-1]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[6+j])
            begin
                for (int k = 0; k < smi_pkg::NENT; k++)
                begin
                    rem_reg[j][k] <= ge[k] ? df[k][smi_pkg::DETW-1:0]
                                           : t[k][smi_pkg::DETW-1:0];
                    low_reg[j][k] <= {low_reg[j-1][k][smi_pkg::DW-2:0], 1'b0};
                    q_reg[j][k]   <= {q_reg[j-1][k][smi_pkg::DW-2:0], ge[k]};
                    ovf_reg[j][k] <= ovf_reg[j-1][k];
                    neg_reg[j][k] <= neg_reg[j-1][k];
                end
                dabs_reg[j] <= dabs_reg[j-1];
                dz_reg[j]   <= dz_reg[j-1];
                sg_reg[j]   <= sg_reg[j-1];
            end
        end
    end

    // ---- last stage: sign, clip, zero on singular
    localparam smi_pkg::ent_t MAXV = {1'b0, {(smi_pkg::DW-1){1'b1}}};
    localparam smi_pkg::ent_t MINV = {1'b1, {(smi_pkg::DW-1){1'b0}}};

    smi_pkg::ent_t  qo_next [smi_pkg::NENT];
    logic           sat_next;
    logic           clip;
    logic [smi_pkg::DW-1:0] qv;
    smi_pkg::ent_t  qo_reg [smi_pkg::NENT];
    logic           sing_o_reg;
    logic           sat_o_reg;

    always_comb
    begin
        sat_next = 1'b0;
        for (int k = 0; k < smi_pkg::NENT; k++)
        begin
            qv = q_reg[smi_pkg::DW][k];
            if (neg_reg[smi_pkg::DW][k])
            begin
                clip       = ovf_reg[smi_pkg::DW][k] || (qv > MINV);
                qo_next[k] = clip ? MINV : -qv;
            end
            else
            begin
                clip       = ovf_reg[smi_pkg::DW][k] || qv[smi_pkg::DW-1];
                qo_next[k] = clip ? MAXV : qv;
            end
            if (dz_reg[smi_pkg::DW])
            begin
                clip       = 1'b0;
                qo_next[k] = '0;
            end
            sat_next = sat_next || clip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[smi_pkg::NST-1])
        begin
            qo_reg     <= qo_next;
            sing_o_reg <= sg_reg[smi_pkg::DW];
            sat_o_reg  <= sat_next;
        end
    end

    assign inv.valid     = vld_reg[smi_pkg::NST-1];
    assign inv.q00       = qo_reg[0];
    assign inv.q01       = qo_reg[1];
    assign inv.q02       = qo_reg[2];
    assign inv.q10       = qo_reg[3];
    assign inv.q11       = qo_reg[4];
    assign inv.q12       = qo_reg[5];
    assign inv.q20       = qo_reg[6];
    assign inv.q21       = qo_reg[7];
    assign inv.q22       = qo_reg[8];
    assign inv.singular  = sing_o_reg;
    assign inv.saturated = sat_o_reg;

    `SMI_AST_NOW(a_sing_zero, inv.valid && inv.singular, inv.q00 == '0 && inv.q11 == '0 && inv.q22 == '0 && !inv.saturated, "singular beat with nonzero result")
    `SMI_AST_NEXT(a_take, mat.valid && mat.ready, vld_reg[0], "accepted beat not in first stage")
    `SMI_AST_NEXT(a_div_hold, vld_reg[6] && !en[6], vld_reg[6] && $stable(dabs_reg[0]), "stalled divider stage lost its beat")

endmodule
